// ===== sv/ptrl_pkg.sv =====
// Shared types and constants of the periodic tick rate limiter.
package ptrl_pkg;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned DELTA_W  = 48;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROG_W   = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
  localparam logic [PROG_W-1:0]   Q16_ONE      = 17'h10000;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE   = 4'd1;

  // Command to the serial divider
  typedef struct packed {
    logic start;  // load operands and run
    logic frac;   // 1: fraction pass (16 quotient bits), 0: modulo pass
  } ptrl_cmd_t;

endpackage

// ===== sv/ptrl_serdiv.sv =====
// Bit-serial restoring divider: modulo of a timestamp, or a Q0.16 fraction.
module ptrl_serdiv #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptrl_pkg::ptrl_cmd_t             cmd,
  input  logic [TIME_WIDTH-1:0]           dividend,
  input  logic [ptrl_pkg::PERIOD_W-1:0]   rem_init,
  input  logic [ptrl_pkg::PERIOD_W-1:0]   divisor,
  output logic                            done,
  output logic [ptrl_pkg::PERIOD_W-1:0]   rem,
  output logic [ptrl_pkg::FRAC_BITS-1:0]  quot
);

  localparam int unsigned CNT_W = $clog2(TIME_WIDTH + 1);
  localparam int unsigned PW    = ptrl_pkg::PERIOD_W;

  logic [CNT_W-1:0]                  cnt_r;
  logic                              done_r;
  logic [TIME_WIDTH-1:0]             div_r;
  logic [PW-1:0]                     rem_r;
  logic [ptrl_pkg::FRAC_BITS-1:0]    quot_r;

  logic [PW:0]   rem_sh;
  logic [PW:0]   rem_sub;
  logic          ge;
  logic [PW-1:0] rem_step;

  // one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, div_r[TIME_WIDTH-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    ge       = (rem_sh >= {1'b0, divisor});
    rem_step = ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r  <= cmd.frac ? CNT_W'(ptrl_pkg::FRAC_BITS) : CNT_W'(TIME_WIDTH);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_r  <= cmd.frac ? '0 : dividend;
      rem_r  <= cmd.frac ? rem_init : '0;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      div_r  <= {div_r[TIME_WIDTH-2:0], 1'b0};
      rem_r  <= rem_step;
      quot_r <= {quot_r[ptrl_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign quot = quot_r;

endmodule

// ===== sv/periodic_tick_rate_limiter.sv =====
// Top level of the periodic tick rate limiter.
// Usage: each transfer on the in_ channel is a poll carrying the current
// free-running timestamp (in_now_time, wraps at 2^TIME_WIDTH). Every poll
// yields exactly one transfer on the out_ channel: out_fired, the last
// reported delta (out_delta_ticks, held between signals) and the cycle
// progress after the poll in Q1.16 (out_progress_q16).
// The cfg_ channel writes period_ticks (index 0, zero reads as 1) and
// delta_mode (index 1); cfg_ready is always high. Write only while idle.
// Each poll passes through a compare step, the fraction steps of the serial
// divider, a step to take the quotient and a load of the output register;
// when a perfect-delta signal fires, the phase remainder is first taken
// bit-serially (modulo steps plus a handoff to the fraction pass).
// Polls are taken one at a time; the single serial divider sets the rate.
// A new poll is taken while a finished result waits in the output register;
// a stalled receiver holds the result and, once the next poll is done,
// holds that poll's completion until the output register frees.
// Reset (synchronous, rst_n low) clears the signal stamp and delta to zero
// and restores period 1000, actual-delta mode.
module periodic_tick_rate_limiter #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // poll channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [TIME_WIDTH-1:0]             in_now_time,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_fired,
  output logic [ptrl_pkg::DELTA_W-1:0]      out_delta_ticks,
  output logic [ptrl_pkg::PROG_W-1:0]       out_progress_q16,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptrl_pkg::PERIOD_W-1:0]     cfg_wdata
);

  localparam int unsigned PW    = ptrl_pkg::PERIOD_W;
  localparam int unsigned DW    = ptrl_pkg::DELTA_W;
  localparam int unsigned CMP_W = (TIME_WIDTH > PW) ? TIME_WIDTH : PW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MOD,
    S_FRAC,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [PW-1:0] period_r;
  logic          mode_r;

  // block state
  logic [TIME_WIDTH-1:0] stamp_r;
  logic [DW-1:0]         delta_r;
  logic                  fired_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [ptrl_pkg::FRAC_BITS-1:0] prog_r;

  // result register
  logic                         out_valid_r;
  logic                         out_fired_r;
  logic [DW-1:0]                out_delta_r;
  logic [ptrl_pkg::PROG_W-1:0]  out_prog_r;

  // evaluation
  logic [PW-1:0]          period_eff;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   fire;
  logic                   in_xfer;
  logic                   out_free;

  // divider interface
  ptrl_pkg::ptrl_cmd_t             div_cmd;
  logic [PW-1:0]                   div_rem_init;
  logic                            div_done;
  logic [PW-1:0]                   div_rem;
  logic [ptrl_pkg::FRAC_BITS-1:0]  div_quot;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    period_eff = (period_r == '0) ? PW'(1) : period_r;
    elapsed    = now_r - stamp_r;
    fire       = (CMP_W'(elapsed) >= CMP_W'(period_eff));

    div_cmd      = '0;
    div_rem_init = '0;
    case (state_r)
      S_EVAL: begin
        // perfect-delta signal needs elapsed mod period first
        div_cmd.start = 1'b1;
        div_cmd.frac  = !(fire && mode_r);
        // no signal: elapsed is below the period, so it fits
        // actual-delta signal: stamp moves to now, elapsed after is zero
        div_rem_init  = fire ? '0 : PW'(elapsed);
      end
      S_MOD: begin
        if (div_done) begin
          div_cmd.start = 1'b1;
          div_cmd.frac  = 1'b1;
          div_rem_init  = div_rem;  // elapsed after the step is the remainder
        end
      end
      default: begin
      end
    endcase
  end

  ptrl_serdiv #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (elapsed),
    .rem_init (div_rem_init),
    .divisor  (period_eff),
    .done     (div_done),
    .rem      (div_rem),
    .quot     (div_quot)
  );

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= ptrl_pkg::PERIOD_RESET;
      mode_r      <= 1'b0;
      stamp_r     <= '0;
      delta_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptrl_pkg::CFG_PERIOD_TICKS: period_r <= cfg_wdata;
          ptrl_pkg::CFG_DELTA_MODE:   mode_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      // in S_OUT a new result takes the register's place instead
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          fired_r <= fire;
          if (fire && mode_r) begin
            delta_r <= DW'(period_eff);
            state_r <= S_MOD;
          end else begin
            if (fire) begin
              delta_r <= DW'(elapsed);
              stamp_r <= now_r;
            end
            state_r <= S_FRAC;
          end
        end
        S_MOD: begin
          if (div_done) begin
            stamp_r <= now_r - TIME_WIDTH'(div_rem);
            state_r <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (div_done) begin
            prog_r  <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_fired_r <= fired_r;
            out_delta_r <= delta_r;
            out_prog_r  <= {1'b0, prog_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // poll timestamp capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_now_time;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_delta_ticks  = out_delta_r;
  assign out_progress_q16 = out_prog_r;

  // divider finishes only while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MOD || state_r == S_FRAC))
    else $error("divider done outside a wait state");

  // an accepted poll goes straight to evaluation
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_EVAL))
    else $error("accepted poll not evaluated");

  // progress stays at or below 1.0
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_progress_q16 <= ptrl_pkg::Q16_ONE))
    else $error("progress above 1.0");

  // phase remainder is always below the period
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && div_done) |-> (div_rem < period_eff))
    else $error("modulo remainder not below period");

endmodule
